### src/counting_semaphore_fifo_wait_top_defines.svh
// Assertion macros shared by the semaphore RTL
`ifndef COUNTING_SEMAPHORE_FIFO_WAIT_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAIT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CSFW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CSFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/csfw_pkg.sv
package csfw_pkg;

    // Sizing
    localparam int MAX_THREADS = 64;
    localparam int COUNT_BITS  = 16;
    localparam int PTR_W       = $clog2(MAX_THREADS);
    localparam int TOTAL_W     = $clog2(MAX_THREADS + 1);
    localparam int TID_W       = 6;
    localparam int CFG_W       = 16;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [TOTAL_W-1:0]    total_t;

    localparam count_t COUNT_MAX  = '1;
    localparam total_t TOTAL_FULL = total_t'(MAX_THREADS);
    localparam ptr_t   PTR_LAST   = ptr_t'(MAX_THREADS - 1);

    // Request codes
    localparam logic REQ_WAIT   = 1'b0;
    localparam logic REQ_SIGNAL = 1'b1;

    // Status codes
    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_BLOCKED   = 3'd1;
    localparam logic [2:0] ST_NO_WAITER = 3'd2;
    localparam logic [2:0] ST_WOKE      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic             req_type;
        logic [TID_W-1:0] thread_id;
    } in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [TID_W-1:0] woken_thread;
    } out_t;

    // Circular pointer advance
    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

### src/csfw_ram.sv
module csfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/counting_semaphore_fifo_wait_top.sv
// Counting semaphore with a FIFO queue of blocked thread ids held in a RAM.
// Each result passes the stage register (with the RAM read) and then the output register.
// One item per cycle unless the output stalls or a config write blocks input; separate RAM read/write ports.
// Reset (rst_n, async, active low): count and initial count zero, queue empty.
// A configuration write reloads the count and empties the queue at once.
`include "counting_semaphore_fifo_wait_top_defines.svh"

module counting_semaphore_fifo_wait_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  csfw_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output csfw_pkg::out_t                     out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csfw_pkg::CFG_W-1:0]         cfg_data
);

    // Semaphore state
    csfw_pkg::count_t count_reg, count_next;
    csfw_pkg::ptr_t   head_reg, head_next;
    csfw_pkg::ptr_t   tail_reg, tail_next;
    csfw_pkg::total_t total_reg, total_next;

    // Stage after accept: status plus whether the RAM data is the woken id
    logic       s1_valid_reg, s1_valid_next;
    logic [2:0] s1_status_reg, s1_status_next;
    logic       s1_ram_reg, s1_ram_next;

    // Output register
    logic           out_valid_reg, out_valid_next;
    csfw_pkg::out_t out_item_reg, out_item_next;

    logic in_fire;
    logic s1_advance;
    logic ram_we;
    logic ram_re;
    logic [csfw_pkg::TID_W-1:0] ram_rdata;
    csfw_pkg::count_t cfg_count;

    // Handshakes; no item is taken in the cycle of a configuration write
    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = (!s1_valid_reg || s1_advance) && !cfg_valid;
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_item_reg;

    // Clamp the written count to the counter range
    always_comb
    begin
        if (32'(cfg_data) > 32'(csfw_pkg::COUNT_MAX))
        begin
            cfg_count = csfw_pkg::COUNT_MAX;
        end
        else
        begin
            cfg_count = csfw_pkg::count_t'(cfg_data);
        end
    end

    // Request handling: count update and queue pointer moves
    always_comb
    begin
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        total_next     = total_reg;
        s1_status_next = s1_status_reg;
        s1_ram_next    = s1_ram_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        if (cfg_valid)
        begin
            count_next = cfg_count;
            head_next  = '0;
            tail_next  = '0;
            total_next = '0;
        end
        else if (in_fire)
        begin
            s1_ram_next = 1'b0;
            if (in_data.req_type == csfw_pkg::REQ_WAIT)
            begin
                if (count_reg != '0)
                begin
                    count_next     = count_reg - csfw_pkg::count_t'(1);
                    s1_status_next = csfw_pkg::ST_GRANTED;
                end
                else if (total_reg != csfw_pkg::TOTAL_FULL)
                begin
                    ram_we         = 1'b1;
                    tail_next      = csfw_pkg::ptr_next(tail_reg);
                    total_next     = total_reg + csfw_pkg::total_t'(1);
                    s1_status_next = csfw_pkg::ST_BLOCKED;
                end
                else
                begin
                    s1_status_next = csfw_pkg::ST_FULL;
                end
            end
            else
            begin
                if (count_reg != csfw_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + csfw_pkg::count_t'(1);
                end
                if (total_reg != '0)
                begin
                    ram_re         = 1'b1;
                    s1_ram_next    = 1'b1;
                    head_next      = csfw_pkg::ptr_next(head_reg);
                    total_next     = total_reg - csfw_pkg::total_t'(1);
                    s1_status_next = csfw_pkg::ST_WOKE;
                end
                else
                begin
                    s1_status_next = csfw_pkg::ST_NO_WAITER;
                end
            end
        end
    end

    // Pipeline valid flow and output capture
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            out_valid_next             = 1'b1;
            out_item_next.status       = s1_status_reg;
            out_item_next.woken_thread = s1_ram_reg ? ram_rdata : '0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            total_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            total_reg     <= total_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_status_reg <= s1_status_next;
        s1_ram_reg    <= s1_ram_next;
        out_item_reg  <= out_item_next;
    end

    // Wait queue storage
    csfw_ram #(
        .WIDTH (csfw_pkg::TID_W),
        .DEPTH (csfw_pkg::MAX_THREADS)
    ) u_wait_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (in_data.thread_id),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Checks
    `CSFW_ASSERT_NOW(a_total_bound, clk, rst_n, 1'b1,
        total_reg <= csfw_pkg::TOTAL_FULL, "waiter total above queue depth")
    `CSFW_ASSERT_NOW(a_empty_ptrs, clk, rst_n, total_reg == '0,
        head_reg == tail_reg, "empty queue with pointers apart")
    `CSFW_ASSERT_NEXT(a_woke_read, clk, rst_n, in_fire && s1_ram_next && !cfg_valid,
        s1_valid_reg && s1_status_reg == csfw_pkg::ST_WOKE, "woken item lost its status")

endmodule

### test/counting_semaphore_fifo_wait_top_test.sv
module counting_semaphore_fifo_wait_top_test;

    localparam int RANDOM_ITEMS    = 1400;
    localparam int QUIET_TAIL      = 200;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int REPORT_LIMIT    = 20;

    // Directed script: either an item or a load of the initial count
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic                       req;
        logic [csfw_pkg::TID_W-1:0] tid;
        logic [csfw_pkg::CFG_W-1:0] cfg_value;
        logic                       pinned;
        logic [2:0]                 status;
        logic [csfw_pkg::TID_W-1:0] woken;
    } script_row_t;

    localparam int SCRIPT_ROWS = 24;

    localparam script_row_t DIRECTED_SCRIPT [SCRIPT_ROWS] = '{
        // straight out of reset the count is zero
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd0,  16'd0,    1'b1, csfw_pkg::ST_NO_WAITER, 6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd63, 16'd0,    1'b1, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd63, 16'd0,    1'b1, csfw_pkg::ST_BLOCKED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd0,  16'd0,    1'b1, csfw_pkg::ST_BLOCKED,   6'd0},
        // same id queued twice
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd63, 16'd0,    1'b1, csfw_pkg::ST_BLOCKED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd42, 16'd0,    1'b1, csfw_pkg::ST_BLOCKED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd21, 16'd0,    1'b1, csfw_pkg::ST_WOKE,      6'd63},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd42, 16'd0,    1'b1, csfw_pkg::ST_WOKE,      6'd0},
        // reload at the top of the range while two ids still wait
        '{ROW_CFG,  csfw_pkg::REQ_WAIT,   6'd0,  16'hFFFF, 1'b0, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd5,  16'd0,    1'b1, csfw_pkg::ST_NO_WAITER, 6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd1,  16'd0,    1'b1, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd2,  16'd0,    1'b1, csfw_pkg::ST_NO_WAITER, 6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd3,  16'd0,    1'b1, csfw_pkg::ST_NO_WAITER, 6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd7,  16'd0,    1'b0, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_CFG,  csfw_pkg::REQ_WAIT,   6'd0,  16'd1,    1'b0, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd9,  16'd0,    1'b1, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd10, 16'd0,    1'b1, csfw_pkg::ST_BLOCKED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd0,  16'd0,    1'b1, csfw_pkg::ST_WOKE,      6'd10},
        // queue drained by the last wake, so nobody left
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd0,  16'd0,    1'b1, csfw_pkg::ST_NO_WAITER, 6'd0},
        '{ROW_CFG,  csfw_pkg::REQ_WAIT,   6'd0,  16'd0,    1'b0, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd33, 16'd0,    1'b1, csfw_pkg::ST_BLOCKED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd44, 16'd0,    1'b1, csfw_pkg::ST_WOKE,      6'd33},
        '{ROW_ITEM, csfw_pkg::REQ_WAIT,   6'd0,  16'd0,    1'b0, csfw_pkg::ST_GRANTED,   6'd0},
        '{ROW_ITEM, csfw_pkg::REQ_SIGNAL, 6'd63, 16'd0,    1'b0, csfw_pkg::ST_GRANTED,   6'd0}
    };

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    csfw_pkg::in_t              in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    csfw_pkg::out_t             out_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [csfw_pkg::CFG_W-1:0] cfg_data  = '0;

    // Fixed expectation travelling alongside the offered item
    logic           pin_valid  = 1'b0;
    csfw_pkg::out_t pin_result = '0;

    // Semaphore mirror
    csfw_pkg::count_t           unit_count = '0;
    logic [csfw_pkg::TID_W-1:0] parked_threads [$];
    csfw_pkg::out_t             pending_outcomes [$];

    bit hold_off_request = 1'b0;
    bit sender_idles     = 1'b1;
    bit receiver_idles   = 1'b1;

    int items_sent      = 0;
    int results_checked = 0;
    int loads_written   = 0;
    int fail_count      = 0;
    int quiet_cycles    = 0;
    int status_tally [0:4] = '{0, 0, 0, 0, 0};

    counting_semaphore_fifo_wait_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Outcome of one request; updates the mirrored count and queue
    function automatic csfw_pkg::out_t semaphore_outcome(input csfw_pkg::in_t req);
        csfw_pkg::out_t res;
        res = '0;
        if (req.req_type == csfw_pkg::REQ_WAIT)
        begin
            if (unit_count != '0)
            begin
                unit_count = unit_count - csfw_pkg::count_t'(1);
                res.status = csfw_pkg::ST_GRANTED;
            end
            else if (parked_threads.size() < csfw_pkg::MAX_THREADS)
            begin
                parked_threads.push_back(req.thread_id);
                res.status = csfw_pkg::ST_BLOCKED;
            end
            else
            begin
                res.status = csfw_pkg::ST_FULL;
            end
        end
        else
        begin
            // saturate at the top, but still pop a waiter
            if (unit_count != csfw_pkg::COUNT_MAX)
            begin
                unit_count = unit_count + csfw_pkg::count_t'(1);
            end
            if (parked_threads.size() != 0)
            begin
                res.status       = csfw_pkg::ST_WOKE;
                res.woken_thread = parked_threads.pop_front();
            end
            else
            begin
                res.status = csfw_pkg::ST_NO_WAITER;
            end
        end
        return res;
    endfunction

    function automatic csfw_pkg::in_t random_request(input int wait_percent);
        csfw_pkg::in_t r;
        r.req_type  = ($urandom_range(0, 99) < wait_percent) ? csfw_pkg::REQ_WAIT
                                                              : csfw_pkg::REQ_SIGNAL;
        r.thread_id = csfw_pkg::TID_W'($urandom_range(0, (1 << csfw_pkg::TID_W) - 1));
        return r;
    endfunction

    // Offer one item, with an occasional idle burst in front of it
    task automatic send_request(input csfw_pkg::in_t d, input logic pin,
                                input csfw_pkg::out_t pinned);
        int gap;
        gap = 0;
        if (sender_idles && ($urandom_range(0, 3) == 0))
        begin
            gap = $urandom_range(1, 11);
        end
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= d;
        pin_valid  <= pin;
        pin_result <= pinned;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results;
        if (in_valid)
        begin
            in_valid <= 1'b0;
        end
        @(posedge clk);
        while (results_checked != items_sent)
        begin
            @(posedge clk);
        end
    endtask

    // Reload the semaphore; only done with nothing in flight
    task automatic load_initial_count(input logic [csfw_pkg::CFG_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        loads_written++;
    endtask

    // Receiver: ready runs, short stalls and the long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (receiver_idles && ($urandom_range(0, 2) == 0))
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Result check, config mirror and prediction at each edge
    always @(posedge clk)
    begin : track_and_check
        csfw_pkg::out_t wanted;
        csfw_pkg::out_t outcome;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result, expected none, %s %0d woken %0d",
                                 $time, "actual status", out_data.status,
                                 out_data.woken_thread);
                    end
                end
                else
                begin
                    wanted = pending_outcomes.pop_front();
                    if (out_data.status !== wanted.status)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: status mismatch, expected %0d, actual %0d",
                                     $time, wanted.status, out_data.status);
                        end
                    end
                    if (out_data.woken_thread !== wanted.woken_thread)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: woken_thread mismatch, expected %0d, actual %0d",
                                     $time, wanted.woken_thread, out_data.woken_thread);
                        end
                    end
                end
                results_checked++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data > csfw_pkg::COUNT_MAX)
                begin
                    unit_count = csfw_pkg::COUNT_MAX;
                end
                else
                begin
                    unit_count = csfw_pkg::count_t'(cfg_data);
                end
                parked_threads.delete();
            end
            if (in_valid && in_ready)
            begin
                outcome = semaphore_outcome(in_data);
                status_tally[outcome.status]++;
                pending_outcomes.push_back(pin_valid ? pin_result : outcome);
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        csfw_pkg::in_t  step_in;
        csfw_pkg::out_t step_out;
        int             phase;
        int             base;
        int             preload;
        phase = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            if (DIRECTED_SCRIPT[i].kind == ROW_CFG)
            begin
                load_initial_count(DIRECTED_SCRIPT[i].cfg_value);
            end
            else
            begin
                step_in.req_type      = DIRECTED_SCRIPT[i].req;
                step_in.thread_id     = DIRECTED_SCRIPT[i].tid;
                step_out.status       = DIRECTED_SCRIPT[i].status;
                step_out.woken_thread = DIRECTED_SCRIPT[i].woken;
                send_request(step_in, DIRECTED_SCRIPT[i].pinned, step_out);
            end
        end

        // random phases, each after a reload
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (items_sent - base > RANDOM_ITEMS - QUIET_TAIL)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            case (phase % 4)
                0:
                begin
                    // fill the queue past full, then send a run of signals that wakes most or all waiters
                    preload = $urandom_range(0, 2);
                    load_initial_count(csfw_pkg::CFG_W'(preload));
                    if (phase == 0)
                    begin
                        hold_off_request = 1'b1;
                    end
                    repeat (preload + $urandom_range(65, 68))
                    begin
                        step_in.req_type  = csfw_pkg::REQ_WAIT;
                        step_in.thread_id =
                            csfw_pkg::TID_W'($urandom_range(0, (1 << csfw_pkg::TID_W) - 1));
                        send_request(step_in, 1'b0, '0);
                    end
                    repeat ($urandom_range(60, 72))
                    begin
                        step_in.req_type  = csfw_pkg::REQ_SIGNAL;
                        step_in.thread_id =
                            csfw_pkg::TID_W'($urandom_range(0, (1 << csfw_pkg::TID_W) - 1));
                        send_request(step_in, 1'b0, '0);
                    end
                end
                1:
                begin
                    // count hovering around zero, short queue
                    load_initial_count(csfw_pkg::CFG_W'($urandom_range(0, 4)));
                    repeat (80) send_request(random_request(50), 1'b0, '0);
                end
                2:
                begin
                    // near the top of the count range
                    load_initial_count(csfw_pkg::CFG_W'(int'(csfw_pkg::COUNT_MAX)
                                                        - int'($urandom_range(0, 2))));
                    repeat (40) send_request(random_request(25), 1'b0, '0);
                    repeat (40) send_request(random_request(75), 1'b0, '0);
                end
                default:
                begin
                    // any count, any mix
                    load_initial_count(
                        csfw_pkg::CFG_W'($urandom_range(0, (1 << csfw_pkg::CFG_W) - 1)));
                    repeat (60) send_request(random_request($urandom_range(20, 80)), 1'b0, '0);
                end
            endcase
            phase++;
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, pending_outcomes.size());
        end

        $display("Ran %0d requests over %0d reloads of the initial count, with bursty stalls",
                 items_sent, loads_written);
        $display("and a long receiver hold-off: %0d granted, %0d queued, %0d no waiter, %s",
                 status_tally[csfw_pkg::ST_GRANTED], status_tally[csfw_pkg::ST_BLOCKED],
                 status_tally[csfw_pkg::ST_NO_WAITER],
                 $sformatf("%0d woke, %0d full", status_tally[csfw_pkg::ST_WOKE],
                           status_tally[csfw_pkg::ST_FULL]));
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
